// ----- src/cls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_pkg: shared constants for the combined LCG shuffle generator
// Moduli, multipliers and Schrage factors of both generators, and the
// reciprocals that turn the quotient z / q into a multiply and a shift.
// ----------------------------------------------------------------------------
package cls_pkg;

    localparam int unsigned VAL_W = 31;
    localparam int unsigned MUL_W = 32;
    localparam int unsigned PROD_W = 64;

    localparam logic [MUL_W-1:0] IM1 = 32'd2147483563;
    localparam logic [MUL_W-1:0] IM2 = 32'd2147483399;
    localparam logic [MUL_W-1:0] IA1 = 32'd40014;
    localparam logic [MUL_W-1:0] IA2 = 32'd40692;
    localparam logic [MUL_W-1:0] IQ1 = 32'd53668;
    localparam logic [MUL_W-1:0] IQ2 = 32'd52774;
    localparam logic [MUL_W-1:0] IR1 = 32'd12211;
    localparam logic [MUL_W-1:0] IR2 = 32'd3791;

    localparam logic [VAL_W-1:0] FIRST_RESET = 31'd1;
    localparam logic [VAL_W-1:0] SECOND_RESET = 31'd123456789;

    // Quotient z / q for any 31-bit z: (z * ceil(2^47 / q)) >> 47
    localparam int unsigned K_SHIFT = 47;
    localparam int unsigned K_W = 16;
    localparam logic [PROD_W-1:0] RECIP1_FULL =
        ((64'd1 << K_SHIFT) + 64'd53668 - 64'd1) / 64'd53668;
    localparam logic [PROD_W-1:0] RECIP2_FULL =
        ((64'd1 << K_SHIFT) + 64'd52774 - 64'd1) / 64'd52774;
    localparam logic [MUL_W-1:0] RECIP1 = RECIP1_FULL[MUL_W-1:0];
    localparam logic [MUL_W-1:0] RECIP2 = RECIP2_FULL[MUL_W-1:0];

endpackage

// ----- src/cls_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_if: request and response channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface cls_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [30:0] seed_value;

    modport source (output valid, output func, output seed_value, input ready);
    modport sink (input valid, input func, input seed_value, output ready);
endinterface

interface cls_rsp_if;
    logic        valid;
    logic        ready;
    logic [30:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink (input valid, input random_value, output ready);
endinterface

// ----- src/combined_lcg_shuffle_random_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_random_core: combined LCG with shuffle table
// Two Schrage-form generators share one registered multiplier under a small
// sequencer; their outputs are mixed through a shuffle table.
// ----------------------------------------------------------------------------
//  channel  dir  payload                 transfer
//  req      in   func, seed_value        req.valid && req.ready
//  rsp      out  random_value            rsp.valid && rsp.ready
//
//  Each Schrage step runs through states K, Q, A, R and F on the shared multiplier.
//  Draw: both generators step, then slot, read and mix; reseed first runs TABLE_DEPTH + 8 warm-up steps.
//  req.ready is high only while the sequencer is idle.
//  A finished result waits in the output register; a new request may enter
//  meanwhile and its result holds until the old one is taken.
//  Reset restores both generators and clears the table through valid bits.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_random_core
    import cls_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    cls_req_if.sink   req,
    cls_rsp_if.source rsp
);

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 8);
    localparam logic [CNT_W-1:0] WARM_LAST = CNT_W'(TABLE_DEPTH + 7);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] SLOT_MAX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [PROD_W-1:0] NDIV =
        64'd1 + (64'd2147483563 - 64'd1) / 64'(TABLE_DEPTH);
    localparam int unsigned SLOT_SHIFT = 31 + $clog2(NDIV);
    localparam logic [PROD_W-1:0] RECIP_SLOT_FULL =
        ((64'd1 << SLOT_SHIFT) + NDIV - 64'd1) / NDIV;
    localparam logic [MUL_W-1:0] RECIP_SLOT = RECIP_SLOT_FULL[MUL_W-1:0];
    localparam logic [VAL_W+1:0] WRAP_ADD = (VAL_W+2)'(IM1) - 33'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_K,
        ST_Q,
        ST_A,
        ST_R,
        ST_F,
        ST_SLOT,
        ST_READ,
        ST_MIX,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_WARM,
        PH_FIRST,
        PH_SECOND
    } phase_t;

    state_t            state_reg;
    phase_t            phase_reg;
    logic [VAL_W-1:0]  first_reg;
    logic [VAL_W-1:0]  second_reg;
    logic [VAL_W-1:0]  last_reg;
    logic [VAL_W-1:0]  z_reg;
    logic [VAL_W-1:0]  out_reg;
    logic              out_valid_reg;
    logic [CNT_W-1:0]  j_reg;
    logic [K_W-1:0]    k_reg;
    logic [MUL_W-1:0]  u_reg;
    logic [IDX_W-1:0]  slot_reg;

    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod;

    logic              gen2;
    logic [MUL_W-1:0]  recip_c;
    logic [MUL_W-1:0]  q_c;
    logic [MUL_W-1:0]  a_c;
    logic [MUL_W-1:0]  r_c;
    logic [MUL_W-1:0]  m_c;
    logic [K_W-1:0]    k_now;
    logic [MUL_W-1:0]  lo_full;
    logic [VAL_W+1:0]  v_raw;
    logic [VAL_W+1:0]  v_fix;
    logic [VAL_W-1:0]  v_res;
    logic [PROD_W-1:0] slot_full;
    logic [IDX_W-1:0]  slot_idx;
    logic [VAL_W+1:0]  diff_raw;
    logic [VAL_W+1:0]  diff_fix;
    logic [VAL_W-1:0]  seed_fix;
    logic              warm_write;
    logic              out_load;

    logic              tbl_wr_en;
    logic [IDX_W-1:0]  tbl_wr_addr;
    logic [VAL_W-1:0]  tbl_wr_data;
    logic              tbl_rd_en;
    logic [VAL_W-1:0]  tbl_rd_data;

    cls_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    cls_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (slot_idx),
        .rd_data (tbl_rd_data)
    );

    assign gen2    = (phase_reg == PH_SECOND);
    assign recip_c = gen2 ? RECIP2 : RECIP1;
    assign q_c     = gen2 ? IQ2 : IQ1;
    assign a_c     = gen2 ? IA2 : IA1;
    assign r_c     = gen2 ? IR2 : IR1;
    assign m_c     = gen2 ? IM2 : IM1;

    assign k_now   = prod[K_SHIFT +: K_W];
    assign lo_full = MUL_W'(z_reg) - prod[MUL_W-1:0];

    assign v_raw = (VAL_W+2)'(u_reg) - (VAL_W+2)'(prod[MUL_W-1:0]);
    assign v_fix = v_raw[VAL_W+1] ? v_raw + (VAL_W+2)'(m_c) : v_raw;
    assign v_res = v_fix[VAL_W-1:0];

    assign slot_full = prod >> SLOT_SHIFT;
    assign slot_idx  = (slot_full >= PROD_W'(TABLE_DEPTH)) ? SLOT_MAX
                                                             : slot_full[IDX_W-1:0];

    assign diff_raw = (VAL_W+2)'(tbl_rd_data) - (VAL_W+2)'(second_reg);
    assign diff_fix = (diff_raw[VAL_W+1] || diff_raw == '0) ? diff_raw + WRAP_ADD
                                                              : diff_raw;

    assign seed_fix   = (req.seed_value == '0) ? FIRST_RESET : req.seed_value;
    assign warm_write = (phase_reg == PH_WARM) && (j_reg < DEPTH_CNT);
    assign out_load   = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_K:
            begin
                mul_a = MUL_W'(z_reg);
                mul_b = recip_c;
            end
            ST_Q:
            begin
                mul_a = MUL_W'(k_now);
                mul_b = q_c;
            end
            ST_A:
            begin
                mul_a = MUL_W'(lo_full[K_W-1:0]);
                mul_b = a_c;
            end
            ST_R:
            begin
                mul_a = MUL_W'(k_reg);
                mul_b = r_c;
            end
            ST_SLOT:
            begin
                mul_a = MUL_W'(last_reg);
                mul_b = RECIP_SLOT;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = j_reg[IDX_W-1:0];
        tbl_wr_data = v_res;
        if (state_reg == ST_F && warm_write)
        begin
            tbl_wr_en = 1'b1;
        end
        else if (state_reg == ST_MIX)
        begin
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = slot_reg;
            tbl_wr_data = first_reg;
        end
    end

    assign tbl_rd_en = (state_reg == ST_READ);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_FIRST;
            first_reg     <= FIRST_RESET;
            second_reg    <= SECOND_RESET;
            last_reg      <= '0;
            z_reg         <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
            j_reg         <= '0;
            k_reg         <= '0;
            u_reg         <= '0;
            slot_reg      <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        state_reg <= ST_K;
                        if (req.func)
                        begin
                            first_reg  <= seed_fix;
                            second_reg <= seed_fix;
                            z_reg      <= seed_fix;
                            j_reg      <= WARM_LAST;
                            phase_reg  <= PH_WARM;
                        end
                        else
                        begin
                            z_reg     <= first_reg;
                            phase_reg <= PH_FIRST;
                        end
                    end
                end
                ST_K:
                begin
                    state_reg <= ST_Q;
                end
                ST_Q:
                begin
                    k_reg     <= k_now;
                    state_reg <= ST_A;
                end
                ST_A:
                begin
                    state_reg <= ST_R;
                end
                ST_R:
                begin
                    u_reg     <= prod[MUL_W-1:0];
                    state_reg <= ST_F;
                end
                ST_F:
                begin
                    unique case (phase_reg)
                        PH_WARM:
                        begin
                            first_reg <= v_res;
                            z_reg     <= v_res;
                            state_reg <= ST_K;
                            if (j_reg == '0)
                            begin
                                last_reg  <= v_res;
                                phase_reg <= PH_FIRST;
                            end
                            else
                            begin
                                j_reg <= j_reg - 1'b1;
                            end
                        end
                        PH_FIRST:
                        begin
                            first_reg <= v_res;
                            z_reg     <= second_reg;
                            phase_reg <= PH_SECOND;
                            state_reg <= ST_K;
                        end
                        default:
                        begin
                            second_reg <= v_res;
                            state_reg  <= ST_SLOT;
                        end
                    endcase
                end
                ST_SLOT:
                begin
                    state_reg <= ST_READ;
                end
                ST_READ:
                begin
                    slot_reg  <= slot_idx;
                    state_reg <= ST_MIX;
                end
                ST_MIX:
                begin
                    last_reg  <= diff_fix[VAL_W-1:0];
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        out_reg   <= last_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.random_value = out_reg;

endmodule

// ----- src/cls_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_mul: shared registered multiplier
// One 32 x 32 unsigned multiply per cycle, product registered.
// ----------------------------------------------------------------------------
module cls_mul
    import cls_pkg::*;
(
    input  logic              clk,
    input  logic [MUL_W-1:0]  a,
    input  logic [MUL_W-1:0]  b,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

// ----- src/cls_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_table: shuffle table
// One write and one registered read port; per-entry valid bits make
// unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module cls_table
    import cls_pkg::*;
#(
    parameter int unsigned DEPTH = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [VAL_W-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [VAL_W-1:0]         rd_data
);

    logic [VAL_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [VAL_W-1:0] rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule
